>>> design/rlid_pkg.sv
// ----------------------------------------------------------------------------
// rlid_pkg
// Shared types and codes for the indexed ring-list deque.
// ----------------------------------------------------------------------------
package rlid_pkg;

  localparam int unsigned DEPTH_DEF = 256;

  // request opcodes; code 7 is unused and does nothing
  localparam logic [2:0] OP_APPEND   = 3'd0;
  localparam logic [2:0] OP_POP_HEAD = 3'd1;
  localparam logic [2:0] OP_POP_TAIL = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_WRITE    = 3'd4;
  localparam logic [2:0] OP_REMOVE   = 3'd5;
  localparam logic [2:0] OP_CLEAR    = 3'd6;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  position;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [7:0]  length;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SH_RD,
    S_SH_WR,
    S_FIN
  } state_t;

endpackage

>>> design/rlid_ram.sv
// ----------------------------------------------------------------------------
// rlid_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rlid_ram #(
  parameter int unsigned DEPTH = rlid_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/ring_list_indexed_deque.sv
// ----------------------------------------------------------------------------
// ring_list_indexed_deque
// Ordered list of 32-bit words in a ring store with indexed access.
// ----------------------------------------------------------------------------
// Holds up to DEPTH-1 words in a ring of DEPTH slots (one slot stays free).
// Requests: append, pop head, pop tail, read/write/remove at a logical index
// counted from the head, and clear. Every request gives exactly one result:
// the word read or removed (zero otherwise), a status (ok, full on append,
// empty or index out of range) and the length after the request, saturated
// at 255. Requests are processed one at a time by a small sequencer around
// a single-port-read, single-port-write slot store whose read data is
// registered. After acceptance a request is executed in S_EXEC; pop head,
// pop tail, read and remove then wait in S_RDWAIT for the registered
// memory read, while append, write, clear and all error cases go straight
// to S_FIN, where the result is loaded into the output register. Remove at
// index first moves N entries to close the gap, each read in S_SH_RD and
// written back in S_SH_WR through the shared memory ports, where N =
// position when position < length - position, otherwise N = length - 1 -
// position. A new request is taken in the same cycle the previous result
// enters the output register, so the output register lets a result wait
// for the consumer while the block is already on the next transfer. Head
// and tail return to slot zero whenever the list becomes empty.
// ----------------------------------------------------------------------------
module ring_list_indexed_deque #(
  parameter int unsigned DEPTH = rlid_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlid_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rlid_pkg::out_item_t out_data
);

  import rlid_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  // compare width: covers both the 8-bit position and the slot count
  localparam int unsigned CW = (AW > 8) ? AW : 8;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  // ---------------------------------------------------------------------
  // ring arithmetic
  // ---------------------------------------------------------------------
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
    return (a == LAST) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST : a - AW'(1);
  endfunction

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [7:0]      pos_r, pos_nxt;
  logic [31:0]     val_r, val_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [AW-1:0]   len_r, len_nxt;
  logic [31:0]     res_val_r, res_val_nxt;
  logic [1:0]      res_st_r, res_st_nxt;
  logic [AW-1:0]   dst_r, dst_nxt;     // slot being filled during a shift
  logic [AW-1:0]   cnt_r, cnt_nxt;     // entries still to move
  logic            dir_r, dir_nxt;     // 1: head side moves toward tail
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // memory port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [31:0]     mem_rdata;

  // ---------------------------------------------------------------------
  // decode of the held request
  // ---------------------------------------------------------------------
  logic [CW-1:0]   pos_cw, len_cw;
  logic [AW-1:0]   pos_aw;
  logic            in_range;
  logic            list_empty;
  logic            list_full;
  logic            last_one;
  logic [AW-1:0]   phys_pos;
  logic [AW-1:0]   tail_dec;
  logic            go_left;
  logic [AW-1:0]   right_cnt;
  logic [AW-1:0]   shift_src;
  logic [7:0]      len_sat;
  logic            out_free;
  logic            in_xfer;

  assign pos_cw     = CW'(pos_r);
  assign len_cw     = CW'(len_r);
  assign pos_aw     = AW'(pos_cw);       // valid only once in_range holds
  assign in_range   = pos_cw < len_cw;
  assign list_empty = (len_r == '0);
  assign list_full  = (len_r == LAST);
  assign last_one   = (len_r == AW'(1));
  assign phys_pos   = wrap_add(head_r, pos_aw);
  assign tail_dec   = slot_dec(tail_r);
  // shift the shorter side to close the gap
  assign go_left    = pos_aw < (len_r - pos_aw);
  assign right_cnt  = len_r - AW'(1) - pos_aw;
  assign shift_src  = dir_r ? slot_dec(dst_r) : slot_inc(dst_r);
  assign len_sat    = (len_cw > CW'(8'hFF)) ? 8'hFF : len_cw[7:0];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_FIN) && out_free);
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r) inside
          OP_POP_HEAD, OP_POP_TAIL: begin
            state_nxt = list_empty ? S_FIN : S_RDWAIT;
          end
          OP_READ, OP_REMOVE: begin
            state_nxt = in_range ? S_RDWAIT : S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_RDWAIT: begin
        if ((op_r == OP_REMOVE) && (cnt_r != '0)) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SH_RD: begin
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        state_nxt = (cnt_r == AW'(1)) ? S_FIN : S_SH_RD;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = in_valid ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer: datapath and memory control
  // ---------------------------------------------------------------------
  always_comb begin
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    dst_nxt       = dst_r;
    cnt_nxt       = cnt_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = val_r;
    mem_re        = 1'b0;
    mem_raddr     = head_r;

    // output register drains on transfer
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_xfer) begin
      op_nxt  = in_data.opcode;
      pos_nxt = in_data.position;
      val_nxt = in_data.value;
    end

    unique case (state_r)
      S_IDLE: begin
      end
      S_EXEC: begin
        res_val_nxt = '0;
        res_st_nxt  = STAT_OK;
        case (op_r)
          OP_APPEND: begin
            if (list_full) begin
              res_st_nxt = STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = tail_r;
              mem_wdata = val_r;
              tail_nxt  = slot_inc(tail_r);
              len_nxt   = len_r + AW'(1);
            end
          end
          OP_POP_HEAD: begin
            if (list_empty) begin
              res_st_nxt = STAT_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_r;
              len_nxt   = len_r - AW'(1);
              if (last_one) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else begin
                head_nxt = slot_inc(head_r);
              end
            end
          end
          OP_POP_TAIL: begin
            if (list_empty) begin
              res_st_nxt = STAT_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = tail_dec;
              len_nxt   = len_r - AW'(1);
              if (last_one) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else begin
                tail_nxt = tail_dec;
              end
            end
          end
          OP_READ: begin
            if (!in_range) begin
              res_st_nxt = STAT_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = phys_pos;
            end
          end
          OP_WRITE: begin
            if (!in_range) begin
              res_st_nxt = STAT_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = phys_pos;
              mem_wdata = val_r;
            end
          end
          OP_REMOVE: begin
            if (!in_range) begin
              res_st_nxt = STAT_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = phys_pos;
              dst_nxt   = phys_pos;
              dir_nxt   = go_left;
              cnt_nxt   = go_left ? pos_aw : right_cnt;
              len_nxt   = len_r - AW'(1);
              // shift walks physical slots, so the ends move right away
              if (last_one) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else if (go_left) begin
                head_nxt = slot_inc(head_r);
              end else begin
                tail_nxt = tail_dec;
              end
            end
          end
          OP_CLEAR: begin
            head_nxt = '0;
            tail_nxt = '0;
            len_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        res_val_nxt = mem_rdata;
      end
      S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = shift_src;
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = mem_rdata;
        dst_nxt   = shift_src;
        cnt_nxt   = cnt_r - AW'(1);
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_out = res_val_r;
          out_data_nxt.status    = res_st_r;
          out_data_nxt.length    = len_sat;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    dst_r      <= dst_nxt;
    cnt_r      <= cnt_nxt;
    dir_r      <= dir_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // slot store
  // ---------------------------------------------------------------------
  rlid_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

>>> tb/sv/rlid_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// rlid_scoreboard_pkg
// Scoreboard for the indexed ring-list deque testbench.
// ----------------------------------------------------------------------------
// Keeps a shadow copy of the ring store, head and tail. Each accepted request
// is applied to the shadow copy and the result it should give is queued.
// Results from the block are checked in order against that queue.
// ----------------------------------------------------------------------------
package rlid_scoreboard_pkg;
  import rlid_pkg::*;

  // code 7 has no operation behind it
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned SLOTS = DEPTH_DEF;

  class rlid_scoreboard;
    logic [31:0] slot_word [SLOTS];
    int unsigned head_slot;
    int unsigned tail_slot;
    out_item_t   awaited [$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned full_seen;
    int unsigned range_seen;
    int unsigned deepest;
    int unsigned op_seen [8];

    function new();
      head_slot = 0;
      tail_slot = 0;
      errors = 0;
      results_seen = 0;
      full_seen = 0;
      range_seen = 0;
      deepest = 0;
      foreach (slot_word[i]) slot_word[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int unsigned length();
      return (tail_slot + SLOTS - head_slot) % SLOTS;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function int unsigned slot_of(int unsigned logical);
      return (head_slot + logical) % SLOTS;
    endfunction

    // apply an accepted request to the shadow list and queue its result
    function void note_request(in_item_t req);
      int unsigned len;
      int unsigned pos;
      int unsigned k;
      out_item_t   res;
      len = length();
      pos = req.position;
      res = '0;
      res.status = STAT_OK;
      op_seen[req.opcode]++;
      case (req.opcode)
        OP_APPEND: begin
          if (len + 1 >= SLOTS) begin
            res.status = STAT_FULL;
          end else begin
            slot_word[tail_slot] = req.value;
            tail_slot = (tail_slot + 1) % SLOTS;
          end
        end
        OP_POP_HEAD: begin
          if (len == 0) begin
            res.status = STAT_RANGE;
          end else begin
            res.value_out = slot_word[head_slot];
            head_slot = (head_slot + 1) % SLOTS;
          end
        end
        OP_POP_TAIL: begin
          if (len == 0) begin
            res.status = STAT_RANGE;
          end else begin
            tail_slot = (tail_slot + SLOTS - 1) % SLOTS;
            res.value_out = slot_word[tail_slot];
          end
        end
        OP_READ: begin
          if (pos >= len) res.status = STAT_RANGE;
          else res.value_out = slot_word[slot_of(pos)];
        end
        OP_WRITE: begin
          if (pos >= len) res.status = STAT_RANGE;
          else slot_word[slot_of(pos)] = req.value;
        end
        OP_REMOVE: begin
          if (pos >= len) begin
            res.status = STAT_RANGE;
          end else begin
            res.value_out = slot_word[slot_of(pos)];
            if (pos < len - pos) begin
              // head side is shorter: move it one slot toward the tail
              for (k = pos; k > 0; k--) slot_word[slot_of(k)] = slot_word[slot_of(k - 1)];
              head_slot = (head_slot + 1) % SLOTS;
            end else begin
              for (k = pos; k + 1 < len; k++) slot_word[slot_of(k)] = slot_word[slot_of(k + 1)];
              tail_slot = (tail_slot + SLOTS - 1) % SLOTS;
            end
          end
        end
        OP_CLEAR: begin
          head_slot = 0;
          tail_slot = 0;
        end
        default: ;
      endcase
      // empty list always parks at slot zero
      if (head_slot == tail_slot) begin
        head_slot = 0;
        tail_slot = 0;
      end
      len = length();
      res.length = (len > 255) ? 8'd255 : len[7:0];
      if (res.status == STAT_FULL) full_seen++;
      if (res.status == STAT_RANGE) range_seen++;
      if (len > deepest) deepest = len;
      awaited.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: value_out %h status %0d length %0d",
               got.value_out, got.status, got.length);
        errors++;
        return;
      end
      want = awaited.pop_front();
      results_seen++;
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %h, actual %h", want.value_out, got.value_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, got.length);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/ring_list_indexed_deque_test.sv
// ----------------------------------------------------------------------------
// ring_list_indexed_deque_test
// Self-checking testbench for the indexed ring-list deque.
// ----------------------------------------------------------------------------
// A short directed sequence hits the empty list, the range checks, the
// unused opcode, head-side and tail-end removes and clear. Random requests
// then sweep the list between empty and full in fill and drain passes, with
// sender and receiver stalls in three traffic mixes, one long receiver
// hold-off that backs the block up, and sender pauses until the block has
// drained. Every result is checked against a scoreboard in transfer order.
// ----------------------------------------------------------------------------
module ring_list_indexed_deque_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlid_pkg::*;
  import rlid_scoreboard_pkg::*;

  localparam int STALL_LIMIT   = 4000;  // cycles with no transfer on either side
  localparam int RANDOM_PER_PH = 584;   // three phases, about 1750 requests
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES   = 50;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  rlid_scoreboard sb;

  // traffic shaping, written by the stimulus process at posedge times only
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_reqs;      // hold-offs asked for by the stimulus
  // owned by the receiver process
  int unsigned holds_done;
  int unsigned rx_hold;
  // owned by the monitor
  int unsigned stall_cycles;

  // fill/drain sweep state for the random requests
  bit          filling;
  int unsigned fill_target;

  ring_list_indexed_deque u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: transfers are sampled at the rising edge, before the block's
  // registers settle, so both channels see the values of the closing cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end else begin
      stall_cycles <= 0;
    end
  end

  // Receiver: random ready, or held low while a hold-off is counting down.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      rx_hold    <= 0;
      holds_done <= hold_reqs;
    end else if (holds_done != hold_reqs) begin
      out_ready  <= 1'b0;
      rx_hold    <= HOLD_CYCLES - 1;
      holds_done <= hold_reqs;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: the block has stopped moving.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Random request, drawn at the falling edge so the scoreboard already
  // reflects every transfer so far. Fill passes lean on append, drain
  // passes on pops and removes; positions mostly land inside the list.
  function automatic in_item_t pick_request();
    in_item_t    req;
    int unsigned len;
    int unsigned roll;
    len = sb.length();
    if (filling && len >= fill_target && (fill_target < 255 || $urandom_range(3) == 0)) begin
      filling = 1'b0;
    end else if (!filling && len == 0 && $urandom_range(2) == 0) begin
      filling = 1'b1;
      fill_target = ($urandom_range(1) == 0) ? 255 : $urandom_range(40, 1);
    end
    req.value = $urandom();
    roll = $urandom_range(15);
    if (roll == 0) req.value = '0;
    if (roll == 1) req.value = '1;
    req.position = $urandom_range(255);
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 70) req.opcode = OP_APPEND;
      else if (roll < 74) req.opcode = OP_POP_HEAD;
      else if (roll < 78) req.opcode = OP_POP_TAIL;
      else if (roll < 86) req.opcode = OP_READ;
      else if (roll < 94) req.opcode = OP_WRITE;
      else if (roll < 98) req.opcode = OP_REMOVE;
      else req.opcode = OP_UNUSED;
    end else begin
      if (roll < 5) req.opcode = OP_APPEND;
      else if (roll < 30) req.opcode = OP_POP_HEAD;
      else if (roll < 55) req.opcode = OP_POP_TAIL;
      else if (roll < 65) req.opcode = OP_READ;
      else if (roll < 75) req.opcode = OP_WRITE;
      else if (roll < 97) req.opcode = OP_REMOVE;
      else if (roll < 99) req.opcode = OP_UNUSED;
      else req.opcode = OP_CLEAR;
    end
    if (req.opcode == OP_READ || req.opcode == OP_WRITE || req.opcode == OP_REMOVE) begin
      roll = $urandom_range(99);
      if (roll < 70) req.position = (len == 0) ? 8'd0 : 8'($urandom_range(len - 1));
      else if (roll < 80) req.position = 8'(len);       // one past the end
      else if (roll < 85) req.position = 8'((len == 0) ? 0 : len - 1);
      else if (roll < 90) req.position = 8'd0;
      // otherwise keep the fully random position
    end
    return req;
  endfunction

  // Offer one request and hold it until transferred. Returns at the
  // rising edge of the transfer; valid stays high for a following request.
  task automatic offer(input in_item_t fixed, input bit fresh);
    in_item_t req;
    @(negedge clk);
    req = fresh ? pick_request() : fixed;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] pos, input logic [31:0] val);
    in_item_t req;
    req.opcode   = op;
    req.position = pos;
    req.value    = val;
    offer(req, 1'b0);
  endtask

  // Sender pause: stop offering until every awaited result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    tx_idle_pct = 23;
    rx_idle_pct = 80;
    hold_reqs   = 0;
    filling     = 1'b1;
    fill_target = 255;    // first sweep always reaches the full list

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty list: every removal and indexed access is out of range
    send_op(OP_POP_HEAD, 8'd0,   32'h0);
    send_op(OP_POP_TAIL, 8'd0,   32'h0);
    send_op(OP_READ,     8'd0,   32'h0);
    send_op(OP_WRITE,    8'd0,   32'hFFFF_FFFF);
    send_op(OP_REMOVE,   8'd0,   32'h0);
    send_op(OP_UNUSED,   8'd255, 32'hFFFF_FFFF);
    // build four entries with extreme words
    send_op(OP_APPEND,   8'd255, 32'h0000_0000);
    send_op(OP_APPEND,   8'd0,   32'hFFFF_FFFF);
    send_op(OP_APPEND,   8'd0,   32'hA5A5_A5A5);
    send_op(OP_APPEND,   8'd0,   32'h5A5A_5A5A);
    send_op(OP_READ,     8'd0,   32'h0);
    send_op(OP_READ,     8'd3,   32'h0);
    send_op(OP_READ,     8'd4,   32'h0);           // index equal to length
    send_op(OP_READ,     8'd255, 32'h0);
    send_op(OP_WRITE,    8'd255, 32'h1234_5678);
    send_op(OP_WRITE,    8'd1,   32'h1234_5678);
    send_op(OP_READ,     8'd1,   32'h0);
    send_op(OP_REMOVE,   8'd255, 32'h0);
    send_op(OP_REMOVE,   8'd1,   32'h0);           // head side shifts
    send_op(OP_REMOVE,   8'd2,   32'h0);           // tail side, last entry, nothing shifts
    send_op(OP_POP_TAIL, 8'd0,   32'h0);
    send_op(OP_POP_HEAD, 8'd0,   32'h0);           // list empties, slots park at zero
    send_op(OP_APPEND,   8'd0,   32'h0BAD_F00D);
    send_op(OP_CLEAR,    8'd0,   32'h0);
    send_op(OP_READ,     8'd0,   32'h0);
    wait_drained();

    // random phases: slow receiver, then slow sender, then full speed
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 80 : 0;
      rx_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 23 : 0;
      for (int i = 0; i < RANDOM_PER_PH; i++) begin
        offer('0, 1'b1);
        // at full speed, stop the receiver so the block backs up its input
        if (ph == 2 && i == 150) hold_reqs = hold_reqs + 1;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d append, %0d pop head, %0d pop tail, %0d read,",
             sb.op_seen[OP_APPEND] + sb.op_seen[OP_POP_HEAD] + sb.op_seen[OP_POP_TAIL]
             + sb.op_seen[OP_READ] + sb.op_seen[OP_WRITE] + sb.op_seen[OP_REMOVE]
             + sb.op_seen[OP_CLEAR] + sb.op_seen[OP_UNUSED],
             sb.op_seen[OP_APPEND], sb.op_seen[OP_POP_HEAD], sb.op_seen[OP_POP_TAIL],
             sb.op_seen[OP_READ]);
    $display("  %0d write, %0d remove, %0d clear, %0d unused; %0d full, %0d range, deepest %0d",
             sb.op_seen[OP_WRITE], sb.op_seen[OP_REMOVE], sb.op_seen[OP_CLEAR],
             sb.op_seen[OP_UNUSED], sb.full_seen, sb.range_seen, sb.deepest);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
